FILE: hw/rtl/spq_pkg.sv
// Shared types and constants for the sorted priority queue.
package spq_pkg;

    localparam int QueueDepth = 16;
    localparam int TagWidth   = 32;
    localparam int PrioWidth  = 16;
    localparam int CountWidth = 5;

    localparam logic [1:0] CMD_ENQUEUE = 2'd0;
    localparam logic [1:0] CMD_DEQUEUE = 2'd1;
    localparam logic [1:0] CMD_CLEAR   = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [1:0]                  command;
        logic [TagWidth-1:0]         value_tag;
        logic signed [PrioWidth-1:0] priority_req;
    } spq_item_t;

    typedef struct packed {
        logic [1:0]                  status;
        logic [TagWidth-1:0]         taken_tag;
        logic signed [PrioWidth-1:0] taken_priority;
        logic [TagWidth-1:0]         front_tag;
        logic signed [PrioWidth-1:0] front_priority;
        logic [CountWidth-1:0]       occupancy;
        logic                        is_empty;
    } spq_result_t;

    typedef struct packed {
        logic [TagWidth-1:0]         tag;
        logic signed [PrioWidth-1:0] prio;
    } spq_entry_t;

    typedef struct packed {
        logic insert;
        logic remove;
    } spq_ctrl_t;

endpackage

FILE: hw/rtl/sorted_priority_queue.sv
// Top level of the sorted priority queue: a chain of cells, a count and a result register.
//
//   channel   signals                            direction
//   item      item_valid, item_stall, item       in  (command, tag, priority)
//   result    result_valid, result_stall, result out (status, taken, front, count)
//
// Every cell decides locally from its own entry and its neighbors whether to keep, insert
// or shift, so an accepted command completes at the edge that accepts it.
// The result is held in one output register; a new item is taken whenever that register
// is empty or is being drained in the same cycle.
// Reset clears the count and the result valid flag; the cell contents are not reset.
module sorted_priority_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    output logic                 item_stall,
    input  spq_pkg::spq_item_t   item,
    output logic                 result_valid,
    input  logic                 result_stall,
    output spq_pkg::spq_result_t result
);

    localparam int Depth = spq_pkg::QueueDepth;

    logic [spq_pkg::CountWidth-1:0] count_reg;
    logic [spq_pkg::CountWidth-1:0] count_next;
    logic                           result_valid_reg;
    logic                           result_valid_next;
    spq_pkg::spq_result_t           result_reg;
    spq_pkg::spq_result_t           result_next;

    logic                accept;
    logic                is_full;
    logic                is_empty_now;
    spq_pkg::spq_ctrl_t  ctrl;
    spq_pkg::spq_entry_t new_entry;
    spq_pkg::spq_entry_t entry_q   [Depth];
    spq_pkg::spq_entry_t entry_nx  [Depth];
    logic [Depth-1:0]    occupied;
    logic [Depth-1:0]    after;

    assign item_stall   = result_valid_reg && result_stall;
    assign accept       = item_valid && !item_stall;
    assign is_full      = (count_reg == spq_pkg::CountWidth'(Depth));
    assign is_empty_now = (count_reg == '0);

    assign ctrl.insert = accept && (item.command == spq_pkg::CMD_ENQUEUE) && !is_full;
    assign ctrl.remove = accept && (item.command == spq_pkg::CMD_DEQUEUE) && !is_empty_now;

    assign new_entry.tag  = item.value_tag;
    assign new_entry.prio = item.priority_req;

    genvar i;
    generate
        for (i = 0; i < Depth; i++)
        begin : g_cell
            spq_pkg::spq_entry_t prev_e;
            spq_pkg::spq_entry_t next_e;
            logic                prev_a;

            assign occupied[i] = (spq_pkg::CountWidth'(i) < count_reg);

            if (i == 0)
            begin : g_first
                assign prev_e = '0;
                assign prev_a = 1'b1;
            end
            else
            begin : g_inner
                assign prev_e = entry_q[i-1];
                assign prev_a = after[i-1];
            end

            if (i == Depth - 1)
            begin : g_last
                assign next_e = '0;
            end
            else
            begin : g_more
                assign next_e = entry_q[i+1];
            end

            spq_cell u_cell (
                .clk        (clk),
                .ctrl       (ctrl),
                .new_entry  (new_entry),
                .prev_entry (prev_e),
                .next_entry (next_e),
                .occupied   (occupied[i]),
                .prev_after (prev_a),
                .after      (after[i]),
                .entry      (entry_q[i]),
                .entry_next (entry_nx[i])
            );
        end
    endgenerate

    always_comb
    begin
        count_next = count_reg;
        result_next = '0;
        if (accept)
        begin
            case (item.command)
                spq_pkg::CMD_ENQUEUE:
                begin
                    if (is_full)
                    begin
                        result_next.status = spq_pkg::ST_FULL;
                    end
                    else
                    begin
                        count_next = count_reg + 1'b1;
                    end
                end
                spq_pkg::CMD_DEQUEUE:
                begin
                    if (is_empty_now)
                    begin
                        result_next.status = spq_pkg::ST_EMPTY;
                    end
                    else
                    begin
                        count_next                = count_reg - 1'b1;
                        result_next.taken_tag      = entry_q[0].tag;
                        result_next.taken_priority = entry_q[0].prio;
                    end
                end
                spq_pkg::CMD_CLEAR:
                begin
                    count_next = '0;
                end
                default:
                begin
                    count_next = count_reg;
                end
            endcase
        end
        result_next.occupancy = count_next;
        result_next.is_empty  = (count_next == '0);
        if (count_next != '0)
        begin
            result_next.front_tag      = entry_nx[0].tag;
            result_next.front_priority = entry_nx[0].prio;
        end
    end

    assign result_valid_next = accept || (result_valid_reg && result_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg        <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg        <= count_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            result_reg <= result_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

FILE: hw/rtl/spq_cell.sv
// One storage cell of the sorted chain: holds an entry and shifts with its neighbors.
module spq_cell (
    input  logic               clk,
    input  spq_pkg::spq_ctrl_t ctrl,
    input  spq_pkg::spq_entry_t new_entry,
    input  spq_pkg::spq_entry_t prev_entry,
    input  spq_pkg::spq_entry_t next_entry,
    input  logic               occupied,
    input  logic               prev_after,
    output logic               after,
    output spq_pkg::spq_entry_t entry,
    output spq_pkg::spq_entry_t entry_next
);

    spq_pkg::spq_entry_t entry_reg;

    // A new entry lands behind every held entry of lower or equal priority.
    assign after = occupied && ($signed(entry_reg.prio) <= $signed(new_entry.prio));

    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.insert)
        begin
            if (after)
            begin
                entry_next = entry_reg;
            end
            else if (prev_after)
            begin
                entry_next = new_entry;
            end
            else
            begin
                entry_next = prev_entry;
            end
        end
        else if (ctrl.remove)
        begin
            entry_next = next_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule
